FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/lrx_pkg.sv
package lrx_pkg;

   // default line store depth
   localparam int BUF_LEN_DEF = 64;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] LF_CODE = 8'h0a;
   localparam logic [7:0] CR_CODE = 8'h0d;

   // one classified input item
   typedef struct packed {
      logic       is_read;
      logic       is_lf;
      logic       is_cr;
      logic [7:0] data;
   } item_type;

endpackage

FILE: hdl/lrx_ram.sv
module lrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lrx_front.sv
module lrx_front
   import lrx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_operation,
   input  logic [7:0] req_rx_byte,
   output logic       busy,
   output item_type   head,
   output logic       head_valid,
   input  logic       pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic            push;
   item_type        item;

   // classify the incoming transfer
   always_comb begin
      item.is_read = req_operation;
      item.is_lf   = (req_rx_byte == LF_CODE);
      item.is_cr   = (req_rx_byte == CR_CODE);
      item.data    = req_rx_byte;
   end

   assign busy       = (fill_ff == FW'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

FILE: hdl/lrx_back.sv
module lrx_back
   import lrx_pkg::*;
#(
   parameter int BUF_LEN = BUF_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  item_type                   head,
   input  logic                       head_valid,
   output logic                       pop,
   output logic                       wr_en,
   output logic [$clog2(BUF_LEN)-1:0] wr_addr,
   output logic [7:0]                 wr_data,
   output logic                       rd_en,
   output logic [$clog2(BUF_LEN)-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_has_data,
   output logic [$clog2(BUF_LEN)-1:0] rsp_line_length,
   output logic                       rsp_last
);

   localparam int CW = $clog2(BUF_LEN);

   logic          line_done_ff, line_done_in;
   logic          cr_seen_ff, cr_seen_in;
   logic [CW-1:0] count_ff, count_in;
   logic          play_ff, play_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [CW-1:0] len_ff, len_in;
   logic          valid_ff, valid_in;
   logic          has_ff, has_in;
   logic [CW-1:0] len_out_ff, len_out_in;
   logic          last_ff, last_in;
   logic          play_last;

   assign pop       = head_valid && !play_ff;
   assign wr_addr   = count_ff;
   assign wr_data   = head.data;
   assign rd_addr   = addr_ff;
   assign play_last = (addr_ff == len_ff - 1'b1);

   // execute one queued item, or step the playout
   always_comb begin
      line_done_in = line_done_ff;
      cr_seen_in   = cr_seen_ff;
      count_in     = count_ff;
      play_in      = play_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      valid_in     = 1'b0;
      has_in       = 1'b0;
      len_out_in   = '0;
      last_in      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      if (play_ff) begin
         rd_en      = 1'b1;
         valid_in   = 1'b1;
         has_in     = 1'b1;
         len_out_in = len_ff;
         last_in    = play_last;
         addr_in    = addr_ff + 1'b1;
         if (play_last) begin
            play_in = 1'b0;
         end
      end else if (head_valid) begin
         if (!head.is_read) begin
            // received byte; ignored while a line is complete
            if (!line_done_ff) begin
               if (cr_seen_ff) begin
                  if (head.is_lf) begin
                     line_done_in = 1'b1;
                  end else begin
                     count_in   = '0;
                     cr_seen_in = 1'b0;
                  end
               end else if (head.is_cr) begin
                  cr_seen_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = (count_ff == CW'(BUF_LEN - 1)) ? '0 : count_ff + 1'b1;
               end
            end
         end else if (line_done_ff && (count_ff != '0)) begin
            // start playout and clear the receiver
            play_in      = 1'b1;
            addr_in      = '0;
            len_in       = count_ff;
            line_done_in = 1'b0;
            cr_seen_in   = 1'b0;
            count_in     = '0;
         end else begin
            // empty read
            valid_in = 1'b1;
            last_in  = 1'b1;
            if (line_done_ff) begin
               line_done_in = 1'b0;
               cr_seen_in   = 1'b0;
               count_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_done_ff <= 1'b0;
         cr_seen_ff   <= 1'b0;
         count_ff     <= '0;
         play_ff      <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         line_done_ff <= line_done_in;
         cr_seen_ff   <= cr_seen_in;
         count_ff     <= count_in;
         play_ff      <= play_in;
         valid_ff     <= valid_in;
      end
   end

   // playout and result payload
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      len_ff     <= len_in;
      has_ff     <= has_in;
      len_out_ff <= len_out_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_has_data    = has_ff;
   assign rsp_line_length = len_out_ff;
   assign rsp_last        = last_ff;
   assign rsp_out_byte    = has_ff ? rd_data : 8'h00;

endmodule

FILE: hdl/crlf_line_receiver_core.sv
// Byte transfer: queued, then executed at the head; back handles one per cycle outside playout.
// Read transfer: queued, then starts playout; results come one per cycle, set by the single
// registered read port of the line store; the back pops no queued item until playout ends.
// Empty read: one registered result from the back. busy rises only when the queue is full.
// Synchronous reset clears queue, flags and byte count; the line store is not cleared.
module crlf_line_receiver_core
   import lrx_pkg::*;
#(
   parameter int BUF_LEN = BUF_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_has_data,
   output logic [$clog2(BUF_LEN)-1:0] rsp_line_length,
   output logic                       rsp_last
);

   localparam int CW = $clog2(BUF_LEN);

   item_type      head;
   logic          head_valid;
   logic          pop;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // accept and classify, queue
   lrx_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .busy          (busy),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop)
   );

   // line state and playout
   lrx_back #(
      .BUF_LEN (BUF_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_data    (rsp_has_data),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   // line store
   lrx_ram #(
      .WIDTH (8),
      .DEPTH (BUF_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: hdl/lrx_checker.sv
`include "assert_macros.svh"

module lrx_checker
   import lrx_pkg::*;
#(
   parameter int BUF_LEN = BUF_LEN_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [7:0]                 rsp_out_byte,
   input logic                       rsp_has_data,
   input logic [$clog2(BUF_LEN)-1:0] rsp_line_length,
   input logic                       rsp_last
);

   logic empty_rsp;
   logic data_rsp;
   logic mid_rsp;
   logic empty_zero;

   assign empty_rsp  = rsp_valid && !rsp_has_data;
   assign data_rsp   = rsp_valid && rsp_has_data;
   assign mid_rsp    = rsp_valid && !rsp_last;
   assign empty_zero = rsp_last && (rsp_line_length == '0) && (rsp_out_byte == 8'h00);

   // an empty result is a single, zeroed, final transfer
   `ASSERT_RST(a_empty_shape, clock, reset, empty_rsp |-> empty_zero, "empty result malformed")

   // a data result belongs to a non-empty line
   `ASSERT_RST(a_data_len, clock, reset, data_rsp |-> rsp_line_length != '0, "zero length on data")

   // playout runs without gaps at a constant length
   `ASSERT_RST(a_play, clock, reset, mid_rsp |=> data_rsp && $stable(rsp_line_length), "playout gap")

   // reset leaves no result pending and the queue open
   `ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_valid && !busy, "state after reset")

endmodule

bind crlf_line_receiver_core lrx_checker #(
   .BUF_LEN (BUF_LEN)
) u_lrx_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_has_data    (rsp_has_data),
   .rsp_line_length (rsp_line_length),
   .rsp_last        (rsp_last)
);
